[hdl/assert_macros.svh]
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Check on every rising edge, ignored while reset is high.
`define ACWS_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");

// Check on every rising edge, reset included.
`define ACWS_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("assertion failed");

`else

`define ACWS_ASSERT(lbl, clk, rst, prop)
`define ACWS_ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

[hdl/acws_pkg.sv]
package acws_pkg;

   localparam int unsigned WINDOW   = 16;
   localparam int unsigned CHANNELS = 8;

   localparam int unsigned CH_IN_W  = 3;
   localparam int unsigned FRAME_W  = 24;
   localparam int unsigned SMP_W    = 12;
   localparam int unsigned SMP_LSB  = 2;
   localparam int unsigned AVG_W    = 16;
   localparam int unsigned FILL_W   = 5;
   localparam int unsigned FRAC_W   = 4;

   localparam int unsigned IDX_W      = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam int unsigned CHSEL_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int unsigned CNT_W      = $clog2(WINDOW + 1);
   localparam int unsigned RING_DEPTH = CHANNELS * WINDOW;
   localparam int unsigned ADDR_W     = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
   localparam int unsigned SUM_W      = SMP_W + IDX_W;

   localparam int unsigned DIVD_W    = SUM_W + FRAC_W;
   localparam int unsigned DIV_RADIX = 4;
   localparam int unsigned DIV_STEPS = (DIVD_W + DIV_RADIX - 1) / DIV_RADIX;
   localparam int unsigned DIV_BITS  = DIV_STEPS * DIV_RADIX;
   localparam int unsigned STEP_W    = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;
   localparam int unsigned REM_W     = CNT_W + 1;

   typedef struct packed {
      logic [CHSEL_W-1:0] ch;
      logic [IDX_W-1:0]   slot;
      logic [CNT_W-1:0]   count;
      logic [SMP_W-1:0]   smp;
   } walk_cmd_type;

   typedef struct packed {
      logic [SMP_W-1:0] min;
      logic [SMP_W-1:0] max;
      logic [SUM_W-1:0] sum;
   } walk_stats_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WALK,
      ST_DIV,
      ST_DONE
   } state_type;

endpackage

[hdl/acws_ring_walker.sv]
module acws_ring_walker
   import acws_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           start,
   input  walk_cmd_type   cmd,
   output logic           done,
   output walk_stats_type stats
);

   logic [SMP_W-1:0]   ring [RING_DEPTH];
   logic [ADDR_W-1:0]  wr_addr;
   logic [ADDR_W-1:0]  rd_addr;
   logic [SMP_W-1:0]   data_ff;
   logic [CHSEL_W-1:0] ch_ff;
   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic [IDX_W-1:0]   last_idx_ff;
   logic               issue_ff, issue_in;
   logic               rd_vld_ff;
   logic               rd_last_ff;
   logic               done_ff;
   walk_stats_type     stats_ff;

   assign wr_addr = ADDR_W'(cmd.ch) * ADDR_W'(WINDOW) + ADDR_W'(cmd.slot);
   assign rd_addr = ADDR_W'(ch_ff) * ADDR_W'(WINDOW) + ADDR_W'(idx_ff);

   // write on start; reads begin the cycle after, so they see the new sample
   always_ff @(posedge clock) begin
      if (start) begin
         ring[wr_addr] <= cmd.smp;
      end
      data_ff <= ring[rd_addr];
   end

   always_comb begin
      issue_in = issue_ff;
      idx_in   = idx_ff;
      if (start) begin
         issue_in = 1'b1;
         idx_in   = '0;
      end else if (issue_ff) begin
         if (idx_ff == last_idx_ff) begin
            issue_in = 1'b0;
         end else begin
            idx_in = idx_ff + IDX_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         issue_ff  <= 1'b0;
         rd_vld_ff <= 1'b0;
         done_ff   <= 1'b0;
      end else begin
         issue_ff  <= issue_in;
         rd_vld_ff <= issue_ff;
         done_ff   <= rd_vld_ff && rd_last_ff;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff     <= idx_in;
      rd_last_ff <= (idx_ff == last_idx_ff);
      if (start) begin
         ch_ff        <= cmd.ch;
         last_idx_ff  <= IDX_W'(cmd.count - CNT_W'(1));
         stats_ff.min <= '1;
         stats_ff.max <= '0;
         stats_ff.sum <= '0;
      end else if (rd_vld_ff) begin
         if (data_ff < stats_ff.min) begin
            stats_ff.min <= data_ff;
         end
         if (data_ff > stats_ff.max) begin
            stats_ff.max <= data_ff;
         end
         stats_ff.sum <= stats_ff.sum + SUM_W'(data_ff);
      end
   end

   assign done  = done_ff;
   assign stats = stats_ff;

endmodule

[hdl/acws_divider.sv]
module acws_divider
   import acws_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [SUM_W-1:0] sum,
   input  logic [CNT_W-1:0] divisor,
   output logic             done,
   output logic [AVG_W-1:0] quotient
);

   logic [DIVD_W-1:0]   dividend;
   logic [DIV_BITS-1:0] q_ff, q_in;
   logic [REM_W-1:0]    rem_ff, rem_in;
   logic [CNT_W-1:0]    div_ff;
   logic [STEP_W-1:0]   step_ff;
   logic                busy_ff;
   logic                done_ff;

   assign dividend = {sum, FRAC_W'(0)};

   // restoring division, DIV_RADIX quotient bits per cycle
   always_comb begin
      q_in   = q_ff;
      rem_in = rem_ff;
      for (int k = 0; k < DIV_RADIX; k++) begin
         rem_in = {rem_in[REM_W-2:0], q_in[DIV_BITS-1]};
         q_in   = {q_in[DIV_BITS-2:0], 1'b0};
         if (rem_in >= {1'b0, div_ff}) begin
            rem_in  = rem_in - {1'b0, div_ff};
            q_in[0] = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && step_ff == STEP_W'(DIV_STEPS - 1)) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         q_ff    <= DIV_BITS'(dividend);
         rem_ff  <= '0;
         div_ff  <= divisor;
         step_ff <= '0;
      end else if (busy_ff) begin
         q_ff    <= q_in;
         rem_ff  <= rem_in;
         step_ff <= step_ff + STEP_W'(1);
      end
   end

   assign done     = done_ff;
   assign quotient = AVG_W'(q_ff);

endmodule

[hdl/adc_channel_window_statistics_core.sv]
// Per-channel window statistics for frames from an eight-channel 12-bit converter.
//
// Input channel (req_*): valid/ready; one item carries a channel number, the 24-bit
// received frame and a transfer-failed flag. The sample is frame bits 13..2, or zero
// on a failed transfer, and is stored in that channel's ring of the last WINDOW samples.
// Result channel (rsp_*): valid/ready; one item per input item with the sample, the
// minimum, maximum and fill count of the channel's stored samples, and the average as
// unsigned fixed point with 4 fraction bits.
//
// Sequencing: one item at a time. The stored entries are walked through the
// single read port of the sample memory, one entry per cycle; the radix-16 divider starts
// when the walk is done and works through DIV_STEPS steps, and then the result is
// loaded into the output register. The next item is accepted only after that load, when
// the block is back in its idle state.
// A result waiting in the output register does not block the next item; the block only
// holds in its final state when a second result is ready before the first was taken.
// Reset clears the write slot and fill count of every channel; the ring needs no clear
// since only written entries are ever read.
`include "assert_macros.svh"

module adc_channel_window_statistics_core
   import acws_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [CH_IN_W-1:0] req_channel,
   input  logic [FRAME_W-1:0] req_rx_frame,
   input  logic               req_transfer_failed,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [SMP_W-1:0]   rsp_sample,
   output logic [SMP_W-1:0]   rsp_window_min,
   output logic [SMP_W-1:0]   rsp_window_max,
   output logic [AVG_W-1:0]   rsp_window_average,
   output logic [FILL_W-1:0]  rsp_window_fill
);

   state_type          state_ff, state_in;
   logic [IDX_W-1:0]   slot_ff [CHANNELS];
   logic [CNT_W-1:0]   fill_ff [CHANNELS];

   logic               accept;
   logic               walk_start;
   logic               walk_done;
   logic               div_start;
   logic               div_done;
   logic               rsp_load;
   logic               req_oor;
   logic [CHSEL_W-1:0] ch_sel;
   logic [SMP_W-1:0]   req_smp;
   logic [IDX_W-1:0]   cur_slot, next_slot;
   logic [CNT_W-1:0]   cur_fill, new_fill;
   walk_cmd_type       walk_cmd;
   walk_stats_type     walk_stats;
   logic [AVG_W-1:0]   quotient;

   logic [SMP_W-1:0]   smp_ff;
   logic               oor_ff;
   logic [CNT_W-1:0]   fill_lat_ff;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [SMP_W-1:0]   rsp_sample_ff;
   logic [SMP_W-1:0]   rsp_min_ff;
   logic [SMP_W-1:0]   rsp_max_ff;
   logic [AVG_W-1:0]   rsp_avg_ff;
   logic [FILL_W-1:0]  rsp_fill_ff;

   // ---------------------------------------------------------------------------
   // Decode the incoming item
   // ---------------------------------------------------------------------------
   assign req_smp = req_transfer_failed ? '0 : req_rx_frame[SMP_LSB +: SMP_W];
   // a channel beyond the configured count touches no channel state and reports zero statistics
   assign req_oor = ({1'b0, req_channel} >= (CH_IN_W + 1)'(CHANNELS));
   assign ch_sel  = req_channel[CHSEL_W-1:0];

   assign req_ready  = (state_ff == ST_IDLE);
   assign accept     = req_valid && req_ready;
   assign walk_start = accept && !req_oor;

   // per-channel write slot and fill count: wrap the slot, saturate the fill
   assign cur_slot  = slot_ff[ch_sel];
   assign cur_fill  = fill_ff[ch_sel];
   assign next_slot = (cur_slot == IDX_W'(WINDOW - 1)) ? '0 : cur_slot + IDX_W'(1);
   assign new_fill  = (cur_fill == CNT_W'(WINDOW)) ? cur_fill : cur_fill + CNT_W'(1);

   assign walk_cmd.ch    = ch_sel;
   assign walk_cmd.slot  = cur_slot;
   assign walk_cmd.count = new_fill;
   assign walk_cmd.smp   = req_smp;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CHANNELS; i++) begin
            slot_ff[i] <= '0;
            fill_ff[i] <= '0;
         end
      end else if (walk_start) begin
         slot_ff[ch_sel] <= next_slot;
         fill_ff[ch_sel] <= new_fill;
      end
   end

   // hold the fields of the item in flight
   always_ff @(posedge clock) begin
      if (accept) begin
         smp_ff      <= req_smp;
         oor_ff      <= req_oor;
         fill_lat_ff <= new_fill;
      end
   end

   // ---------------------------------------------------------------------------
   // Ring walk and average division
   // ---------------------------------------------------------------------------
   acws_ring_walker u_walker (
      .clock (clock),
      .reset (reset),
      .start (walk_start),
      .cmd   (walk_cmd),
      .done  (walk_done),
      .stats (walk_stats)
   );

   acws_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .sum      (walk_stats.sum),
      .divisor  (fill_lat_ff),
      .done     (div_done),
      .quotient (quotient)
   );

   // ---------------------------------------------------------------------------
   // Sequencer
   // ---------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      div_start = 1'b0;
      rsp_load  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = req_oor ? ST_DONE : ST_WALK;
            end
         end
         ST_WALK: begin
            if (walk_done) begin
               div_start = 1'b1;
               state_in  = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_done) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            // wait only while the output register still holds an untaken result
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // ---------------------------------------------------------------------------
   // Output register
   // ---------------------------------------------------------------------------
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_sample_ff <= smp_ff;
         rsp_min_ff    <= oor_ff ? '0 : walk_stats.min;
         rsp_max_ff    <= oor_ff ? '0 : walk_stats.max;
         rsp_avg_ff    <= oor_ff ? '0 : quotient;
         rsp_fill_ff   <= oor_ff ? '0 : FILL_W'(fill_lat_ff);
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_sample         = rsp_sample_ff;
   assign rsp_window_min     = rsp_min_ff;
   assign rsp_window_max     = rsp_max_ff;
   assign rsp_window_average = rsp_avg_ff;
   assign rsp_window_fill    = rsp_fill_ff;

   // ---------------------------------------------------------------------------
   // Checks
   // ---------------------------------------------------------------------------
   `ACWS_ASSERT(a_walk_done_in_walk, clock, reset, walk_done |-> state_ff == ST_WALK)
   `ACWS_ASSERT(a_div_done_in_div, clock, reset, div_done |-> state_ff == ST_DIV)
   `ACWS_ASSERT(a_fill_nonzero, clock, reset, (state_ff == ST_DONE && !oor_ff) |-> fill_lat_ff != '0)
   `ACWS_ASSERT(a_rsp_from_done, clock, reset, $rose(rsp_valid_ff) |-> $past(state_ff == ST_DONE))
   `ACWS_ASSERT_ALWAYS(a_reset_idle, clock, $past(reset) |-> (state_ff == ST_IDLE && !rsp_valid_ff))

endmodule

[tb/tb_adc_channel_window_statistics_core.sv]
`timescale 1ns / 1ps

module tb_adc_channel_window_statistics_core;
   import acws_pkg::*;

   localparam int unsigned RANDOM_ITEMS = 700;
   localparam int unsigned MAX_IDLE     = 5;
   // Worst item: full ring walk plus divider, then both idle draws.
   localparam int unsigned DRAIN_CYCLES = 60;
   localparam int unsigned CYCLE_LIMIT  = 200000;

   typedef struct packed {
      logic [CH_IN_W-1:0] channel;
      logic [FRAME_W-1:0] frame;
      logic               failed;
   } adc_frame_type;

   typedef struct packed {
      logic [SMP_W-1:0]  sample;
      logic [SMP_W-1:0]  window_min;
      logic [SMP_W-1:0]  window_max;
      logic [AVG_W-1:0]  window_average;
      logic [FILL_W-1:0] window_fill;
   } window_stats_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic [CH_IN_W-1:0] req_channel = '0;
   logic [FRAME_W-1:0] req_rx_frame = '0;
   logic               req_transfer_failed = 1'b0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic [SMP_W-1:0]   rsp_sample;
   logic [SMP_W-1:0]   rsp_window_min;
   logic [SMP_W-1:0]   rsp_window_max;
   logic [AVG_W-1:0]   rsp_window_average;
   logic [FILL_W-1:0]  rsp_window_fill;

   // Own copy of the per-channel sample rings, write pointers and fill counts.
   logic [SMP_W-1:0] ring_copy [CHANNELS][WINDOW];
   int unsigned      next_slot [CHANNELS];
   int unsigned      stored_count [CHANNELS];

   adc_frame_type    pending_frames [$];
   window_stats_type expected_stats [$];

   int unsigned frames_total    = 0;
   int unsigned frames_launched = 0;
   int unsigned frames_taken    = 0;
   int unsigned results_seen    = 0;
   int unsigned error_count     = 0;
   int unsigned cycle_count     = 0;
   int unsigned launch_gap      = 0;
   int unsigned result_stall    = 0;

   adc_channel_window_statistics_core uut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_channel         (req_channel),
      .req_rx_frame        (req_rx_frame),
      .req_transfer_failed (req_transfer_failed),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_sample          (rsp_sample),
      .rsp_window_min      (rsp_window_min),
      .rsp_window_max      (rsp_window_max),
      .rsp_window_average  (rsp_window_average),
      .rsp_window_fill     (rsp_window_fill)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Store the sample in the channel's ring, then walk the filled slots for the statistics.
   function automatic window_stats_type window_stats_after(adc_frame_type item);
      window_stats_type st;
      int unsigned      ch;
      int unsigned      lo;
      int unsigned      hi;
      int unsigned      total;
      ch = item.channel;
      st = '0;
      st.sample = item.failed ? '0 : item.frame[SMP_LSB +: SMP_W];
      // Out-of-range channel: leave the state alone and zero the statistics.
      if (ch >= CHANNELS) return st;
      ring_copy[ch][next_slot[ch]] = st.sample;
      next_slot[ch] = (next_slot[ch] + 1) % WINDOW;
      if (stored_count[ch] < WINDOW) stored_count[ch]++;
      lo    = 32'hFFFF;
      hi    = 0;
      total = 0;
      // Only slots already written are walked, so the ring needs no reset value.
      for (int unsigned i = 0; i < stored_count[ch]; i++) begin
         if (ring_copy[ch][i] < lo) lo = ring_copy[ch][i];
         if (ring_copy[ch][i] > hi) hi = ring_copy[ch][i];
         total += ring_copy[ch][i];
      end
      st.window_min     = lo[SMP_W-1:0];
      st.window_max     = hi[SMP_W-1:0];
      st.window_average = AVG_W'((total << FRAC_W) / stored_count[ch]);
      st.window_fill    = FILL_W'(stored_count[ch]);
      return st;
   endfunction

   // Random frame, with extra weight on sample values at and next to the extremes.
   function automatic logic [FRAME_W-1:0] random_frame();
      logic [FRAME_W-1:0] f;
      f = FRAME_W'($urandom());
      case ($urandom_range(0, 9))
         0: begin
            f[SMP_LSB +: SMP_W] = '0;
         end
         1: begin
            f[SMP_LSB +: SMP_W] = '1;
         end
         2: begin
            f[SMP_LSB +: SMP_W] = SMP_W'($urandom_range(0, 3));
         end
         3: begin
            f[SMP_LSB +: SMP_W] = SMP_W'($urandom_range(4092, 4095));
         end
         default: begin
         end
      endcase
      return f;
   endfunction

   task automatic queue_frame(int unsigned ch, logic [FRAME_W-1:0] frame, logic failed);
      adc_frame_type item;
      item.channel = CH_IN_W'(ch);
      item.frame   = frame;
      item.failed  = failed;
      pending_frames.push_back(item);
   endtask

   task automatic report_mismatch(string what);
      error_count++;
      $display("%0t: mismatch: %s", $realtime, what);
   endtask

   task automatic compare_field(string field, logic [15:0] got, logic [15:0] want);
      if (got !== want)
         report_mismatch($sformatf("result %0d %s got %0h want %0h",
                                   results_seen, field, got, want));
   endtask

   // Driver: hold each item until taken, then idle for a drawn number of cycles.
   // Every fourth run of 50 items goes through with no idling at all.
   always @(posedge clock) begin
      if (reset) begin
         req_valid  <= 1'b0;
         launch_gap <= 0;
      end else begin
         if (req_valid && req_ready) begin
            adc_frame_type taken;
            taken.channel = req_channel;
            taken.frame   = req_rx_frame;
            taken.failed  = req_transfer_failed;
            expected_stats.push_back(window_stats_after(taken));
            frames_taken <= frames_taken + 1;
         end
         // Hold valid and payload while the item waits for ready.
         if (!(req_valid && !req_ready)) begin
            if (launch_gap != 0) begin
               req_valid  <= 1'b0;
               launch_gap <= launch_gap - 1;
            end else if (pending_frames.size() != 0) begin
               adc_frame_type item;
               item = pending_frames.pop_front();
               req_channel         <= item.channel;
               req_rx_frame        <= item.frame;
               req_transfer_failed <= item.failed;
               req_valid           <= 1'b1;
               launch_gap <= ((frames_launched / 50) % 4 == 3) ? 0
                             : $urandom_range(0, MAX_IDLE);
               frames_launched <= frames_launched + 1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: check each taken result against the oldest expectation, then stall
   // the result side for a drawn number of cycles; some runs go without stalls.
   always @(posedge clock) begin
      int unsigned stall;
      window_stats_type want;
      if (reset) begin
         rsp_ready    <= 1'b0;
         result_stall <= 0;
      end else begin
         stall = result_stall;
         if (rsp_valid && rsp_ready) begin
            if (expected_stats.size() == 0) begin
               report_mismatch($sformatf("result %0d with no item outstanding",
                                         results_seen));
            end else begin
               want = expected_stats.pop_front();
               compare_field("sample", 16'(rsp_sample), 16'(want.sample));
               compare_field("window_min", 16'(rsp_window_min), 16'(want.window_min));
               compare_field("window_max", 16'(rsp_window_max), 16'(want.window_max));
               compare_field("window_average", rsp_window_average, want.window_average);
               compare_field("window_fill", 16'(rsp_window_fill), 16'(want.window_fill));
            end
            results_seen <= results_seen + 1;
            stall = ((results_seen / 40) % 4 == 1) ? 0 : $urandom_range(0, MAX_IDLE);
         end
         if (stall != 0) begin
            rsp_ready    <= 1'b0;
            result_stall <= stall - 1;
         end else begin
            rsp_ready    <= 1'b1;
            result_stall <= 0;
         end
      end
   end

   // Watchdog: end a hung run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("tb_adc_channel_window_statistics_core: errors");
         $finish;
      end
   end

   initial begin
      for (int unsigned c = 0; c < CHANNELS; c++) begin
         next_slot[c]    = 0;
         stored_count[c] = 0;
         for (int unsigned s = 0; s < WINDOW; s++) ring_copy[c][s] = '0;
      end

      // Sample extremes, bits outside the sample field, and failed transfers.
      queue_frame(0, 24'h000000, 1'b0);
      queue_frame(0, 24'hFFFFFF, 1'b0);
      queue_frame(0, 24'h003FFC, 1'b0);
      queue_frame(0, 24'hFFC003, 1'b0);
      queue_frame(0, 24'hFFFFFF, 1'b1);
      queue_frame(7, 24'h000004, 1'b0);
      queue_frame(7, 24'h002000, 1'b0);
      // Fill one ring past WINDOW so the fill count saturates and the pointer wraps.
      for (int unsigned i = 0; i <= WINDOW; i++) begin
         case (i % 4)
            0: queue_frame(3, 24'h003FFC, 1'b0);
            1: queue_frame(3, 24'h000000, 1'b0);
            2: queue_frame(3, random_frame(), 1'b1);
            default: queue_frame(3, 24'h002000, 1'b0);
         endcase
      end

      // Random traffic across all channels; roughly one failed transfer in eight.
      for (int unsigned i = 0; i < RANDOM_ITEMS; i++)
         queue_frame($urandom_range(0, 7), random_frame(), $urandom_range(0, 7) == 0);
      frames_total = pending_frames.size();

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Advance until every item is taken and every result has come back.
      while (frames_taken < frames_total || expected_stats.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (error_count == 0) begin
         $display("tb_adc_channel_window_statistics_core: clean");
      end else begin
         $display("tb_adc_channel_window_statistics_core: errors");
      end
      $finish;
   end

endmodule
